// ===== sv/dics_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and widths for the discrete inverse-cdf sampler
// no dependencies; compiled before every other file of the block

package dics_pkg;

    // default sizing of the block
    localparam int DEF_MAX_CATEGORIES = 256;
    localparam int DEF_TOTAL_BITS     = 32;

    // fixed field widths
    localparam int CMD_W       = 2;
    localparam int ENTRY_W     = 8;
    localparam int WEIGHT_W    = 32;
    localparam int DRAW_W      = 32;
    localparam int CAT_W       = 8;
    localparam int COUNT_W     = 9;
    localparam int NC_W        = 9;
    localparam int THR_W       = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int MUL_W       = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_PREPARE = 2'd1,
        CMD_SAMPLE  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUM_CATEGORIES     = 2'd0,
        REG_WEIGHTS_CUMULATIVE = 2'd1,
        REG_ZERO_THRESHOLD     = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_READ,
        ST_P_ADD,
        ST_P_TEST,
        ST_S_TOP,
        ST_S_MUL,
        ST_S_ACC,
        ST_S_CHECK,
        ST_S_CMP,
        ST_S_LAST,
        ST_S_IDX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ENTRY_W-1:0]  entry_index;
        logic [WEIGHT_W-1:0] weight;
        logic [DRAW_W-1:0]   draw;
    } req_t;

    typedef struct packed {
        logic [NC_W-1:0]  num_categories;
        logic             weights_cumulative;
        logic [THR_W-1:0] zero_threshold;
    } cfg_t;

    typedef struct packed {
        logic [CAT_W-1:0]   category;
        logic [COUNT_W-1:0] nonzero_count;
        logic               is_report;
        logic               no_support;
    } res_t;

endpackage

// ===== sv/dics_if.sv =====
`timescale 1ns / 1ps
// handshake channels of the sampler: command items, results, register writes
// depends on dics_pkg for the field widths

interface dics_item_if import dics_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [ENTRY_W-1:0]  entry_index;
    logic [WEIGHT_W-1:0] weight;
    logic [DRAW_W-1:0]   draw;

    modport source (output valid, command, entry_index, weight, draw, input ready);
    modport sink   (input valid, command, entry_index, weight, draw, output ready);
endinterface

interface dics_result_if import dics_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CAT_W-1:0]   category;
    logic [COUNT_W-1:0] nonzero_count;
    logic               is_report;
    logic               no_support;

    modport source (output valid, category, nonzero_count, is_report, no_support,
                    input ready);
    modport sink   (input valid, category, nonzero_count, is_report, no_support,
                    output ready);
endinterface

interface dics_cfg_if import dics_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/dics_engine.sv =====
`timescale 1ns / 1ps
// sequencer, tables and shared adder / multiplier of the sampler
// depends on dics_pkg

module dics_engine import dics_pkg::*; #(
    parameter int MAX_CATEGORIES = DEF_MAX_CATEGORIES,
    parameter int TOTAL_BITS     = DEF_TOTAL_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    input  cfg_t cfg,
    output logic idle,
    output logic done,
    input  logic take,
    output res_t res
);

    localparam int IDX_W = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
    localparam int CNT_W = $clog2(MAX_CATEGORIES + 1);
    localparam int KW    = (CNT_W > NC_W) ? CNT_W : NC_W;
    localparam int CW    = (TOTAL_BITS > THR_W) ? TOTAL_BITS : THR_W;
    localparam int NCH   = (TOTAL_BITS + MUL_W - 1) / MUL_W;
    localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int AW    = NCH * MUL_W + DRAW_W;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // tables
    logic [WEIGHT_W-1:0]   weight_table   [MAX_CATEGORIES];
    logic [TOTAL_BITS-1:0] compact_totals [MAX_CATEGORIES];
    logic [IDX_W-1:0]      original_index [MAX_CATEGORIES];

    logic                  wt_we, wt_re, ct_we, ct_re, oi_re;
    logic [IDX_W-1:0]      wt_raddr, ct_raddr, oi_raddr;
    logic [WEIGHT_W-1:0]   wt_rdata_reg;
    logic [TOTAL_BITS-1:0] ct_rdata_reg;
    logic [IDX_W-1:0]      oi_rdata_reg;

    // sequencer state
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      m_reg, m_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [CNT_W-1:0]      sc_reg, sc_next;
    logic                  found_reg, found_next;
    logic [TOTAL_BITS-1:0] run_reg, run_next;
    logic [TOTAL_BITS-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0]      lo_reg, lo_next;
    logic [IDX_W-1:0]      hi_reg, hi_next;
    logic [CH_W-1:0]       c_reg, c_next;
    logic [2*MUL_W-1:0]    prod_reg, prod_next;
    logic [AW-1:0]         acc_reg, acc_next;
    logic [DRAW_W-1:0]     draw_reg, draw_next;
    logic [CAT_W-1:0]      cat_reg, cat_next;
    logic                  rep_reg, rep_next;
    logic                  none_reg, none_next;

    // shared add / subtract unit
    logic [TOTAL_BITS-1:0] alu_a, alu_b;
    logic                  alu_sub;
    logic [TOTAL_BITS:0]   alu_res;

    assign alu_res = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(TOTAL_BITS + 1){alu_sub}})
                   + (TOTAL_BITS + 1)'(alu_sub);

    // threshold comparator: first kept entry tests the total, later ones the step
    logic [TOTAL_BITS-1:0] thr_in;
    logic                  above_thr;

    assign thr_in    = found_reg ? alu_res[TOTAL_BITS-1:0] : run_reg;
    assign above_thr = CW'(thr_in) > CW'(cfg.zero_threshold);

    // weight clamp and saturated running total
    logic [TOTAL_BITS-1:0] w_cl, sat_sum;

    assign w_cl    = (CW'(wt_rdata_reg) > CW'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : TOTAL_BITS'(wt_rdata_reg);
    assign sat_sum = alu_res[TOTAL_BITS] ? TOTAL_MAX : alu_res[TOTAL_BITS-1:0];

    // scaling multiplier, one 32-bit slice of the total per pass
    logic [NCH*MUL_W-1:0]  total_pad;
    logic [MUL_W-1:0]      chunk;
    logic [TOTAL_BITS-1:0] u_val;

    assign total_pad = (NCH * MUL_W)'(ct_rdata_reg);
    assign chunk     = total_pad[c_reg * MUL_W +: MUL_W];
    assign prod_next = chunk * draw_reg;
    assign acc_next  = (acc_reg << MUL_W) + AW'(prod_reg);
    assign u_val     = acc_reg[DRAW_W +: TOTAL_BITS];

    // bisection helpers
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] mid, span;
    logic             wide, le;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + (IDX_W + 1)'(1);
    assign mid     = mid_sum[IDX_W:1];
    assign span    = hi_reg - lo_reg;
    assign wide    = span > IDX_W'(1);
    assign le      = !alu_res[TOTAL_BITS];

    // category count clamped to the table
    logic [KW-1:0]    nc_ext;
    logic [CNT_W-1:0] k_calc, n_inc;
    logic             keep, m_last;

    assign nc_ext = KW'(cfg.num_categories);
    assign k_calc = (nc_ext >= KW'(MAX_CATEGORIES)) ? CNT_W'(MAX_CATEGORIES)
                  : (nc_ext == '0) ? CNT_W'(1) : CNT_W'(nc_ext);
    assign n_inc  = n_reg + CNT_W'(1);
    assign m_last = (m_reg == k_reg - CNT_W'(1));
    assign keep   = found_reg ? (!alu_res[TOTAL_BITS] && (alu_res[TOTAL_BITS-1:0] != '0)
                                 && above_thr)
                              : above_thr;

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        sc_next    = sc_reg;
        found_next = found_reg;
        run_next   = run_reg;
        prev_next  = prev_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        c_next     = c_reg;
        draw_next  = draw_reg;
        cat_next   = cat_reg;
        rep_next   = rep_reg;
        none_next  = none_reg;
        idle       = 1'b0;
        done       = 1'b0;
        wt_we      = 1'b0;
        wt_re      = 1'b0;
        ct_we      = 1'b0;
        ct_re      = 1'b0;
        oi_re      = 1'b0;
        wt_raddr   = m_reg[IDX_W-1:0];
        ct_raddr   = hi_reg;
        oi_raddr   = hi_reg;
        alu_a      = prev_reg;
        alu_b      = w_cl;
        alu_sub    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    case (req.command)
                        CMD_WRITE:
                        begin
                            wt_we = KW'(req.entry_index) < KW'(MAX_CATEGORIES);
                        end
                        CMD_PREPARE:
                        begin
                            m_next     = '0;
                            n_next     = '0;
                            found_next = 1'b0;
                            k_next     = k_calc;
                            state_next = ST_P_READ;
                        end
                        CMD_SAMPLE:
                        begin
                            draw_next = req.draw;
                            rep_next  = 1'b0;
                            cat_next  = '0;
                            none_next = 1'b0;
                            if (cfg.num_categories > NC_W'(1))
                            begin
                                if (sc_reg == '0)
                                begin
                                    none_next  = 1'b1;
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    lo_next    = '0;
                                    hi_next    = IDX_W'(sc_reg - CNT_W'(1));
                                    state_next = ST_S_TOP;
                                end
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_P_READ:
            begin
                wt_re      = 1'b1;
                state_next = ST_P_ADD;
            end

            ST_P_ADD:
            begin
                run_next   = (cfg.weights_cumulative || m_reg == '0) ? w_cl : sat_sum;
                state_next = ST_P_TEST;
            end

            ST_P_TEST:
            begin
                alu_a     = run_reg;
                alu_b     = prev_reg;
                alu_sub   = 1'b1;
                prev_next = run_reg;
                if (keep)
                begin
                    ct_we      = 1'b1;
                    n_next     = n_inc;
                    found_next = 1'b1;
                end
                if (m_last)
                begin
                    sc_next    = n_next;
                    rep_next   = 1'b1;
                    cat_next   = '0;
                    none_next  = (n_next == '0);
                    state_next = ST_DONE;
                end
                else
                begin
                    m_next     = m_reg + CNT_W'(1);
                    state_next = ST_P_READ;
                end
            end

            ST_S_TOP:
            begin
                ct_re      = 1'b1;
                ct_raddr   = hi_reg;
                c_next     = CH_W'(NCH - 1);
                state_next = ST_S_MUL;
            end

            ST_S_MUL:
            begin
                state_next = ST_S_ACC;
            end

            ST_S_ACC:
            begin
                if (c_reg == '0)
                begin
                    state_next = ST_S_CHECK;
                end
                else
                begin
                    c_next     = c_reg - CH_W'(1);
                    state_next = ST_S_MUL;
                end
            end

            ST_S_CHECK:
            begin
                ct_re = 1'b1;
                if (wide)
                begin
                    ct_raddr   = mid;
                    state_next = ST_S_CMP;
                end
                else
                begin
                    ct_raddr   = lo_reg;
                    state_next = ST_S_LAST;
                end
            end

            ST_S_CMP:
            begin
                alu_a   = ct_rdata_reg;
                alu_b   = u_val;
                alu_sub = 1'b1;
                if (le)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid;
                end
                state_next = ST_S_CHECK;
            end

            ST_S_LAST:
            begin
                alu_a      = ct_rdata_reg;
                alu_b      = u_val;
                alu_sub    = 1'b1;
                oi_re      = 1'b1;
                oi_raddr   = le ? lo_reg : hi_reg;
                state_next = ST_S_IDX;
            end

            ST_S_IDX:
            begin
                cat_next   = CAT_W'(oi_rdata_reg);
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                done = 1'b1;
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.category      = cat_reg;
    assign res.nonzero_count = COUNT_W'(sc_reg);
    assign res.is_report     = rep_reg;
    assign res.no_support    = none_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        found_reg <= found_next;
        run_reg   <= run_next;
        prev_reg  <= prev_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        c_reg     <= c_next;
        draw_reg  <= draw_next;
        cat_reg   <= cat_next;
        rep_reg   <= rep_next;
        none_reg  <= none_next;
        if (state_reg == ST_S_MUL)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_S_TOP)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == ST_S_ACC)
        begin
            acc_reg <= acc_next;
        end
    end

    // weight table
    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            weight_table[IDX_W'(req.entry_index)] <= req.weight;
        end
        if (wt_re)
        begin
            wt_rdata_reg <= weight_table[wt_raddr];
        end
    end

    // compacted running totals
    always_ff @(posedge clk)
    begin
        if (ct_we)
        begin
            compact_totals[n_reg[IDX_W-1:0]] <= run_reg;
        end
        if (ct_re)
        begin
            ct_rdata_reg <= compact_totals[ct_raddr];
        end
    end

    // original category of each compacted entry
    always_ff @(posedge clk)
    begin
        if (ct_we)
        begin
            original_index[n_reg[IDX_W-1:0]] <= m_reg[IDX_W-1:0];
        end
        if (oi_re)
        begin
            oi_rdata_reg <= original_index[oi_raddr];
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sc_reg <= CNT_W'(MAX_CATEGORIES))
        else $error("support count beyond table depth");

    a_bisect_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_S_CHECK || state_reg == ST_S_CMP) |-> lo_reg <= hi_reg)
        else $error("bisection bounds crossed");

    a_compact_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ct_we |-> (n_reg < k_reg && found_next))
        else $error("compact write past category count");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !take) |=> (state_reg == ST_DONE && $stable(res)))
        else $error("finished result lost before hand-off");
`endif

endmodule

// ===== sv/discrete_inverse_cdf_sampler_core.sv =====
`timescale 1ns / 1ps
// top level of the discrete inverse-cdf sampler: channels, registers, output stage
// depends on dics_pkg, dics_if and dics_engine
//
// usage
//   item channel: command 0 writes weight into entry entry_index (ignored when
//   beyond the table), command 1 prepares the running totals and compact table,
//   command 2 draws one category for the uniform fraction draw / 2^32
//   result channel: one transaction per prepare (is_report 1) or sample
//   cfg channel: register writes, always ready; the user writes only while the
//   block is idle, which the block itself does not enforce
// sequencing
//   write: no result; prepare: P_READ, P_ADD, P_TEST for each category in use
//   sample: top read, scaling in 32-bit slices, bisection of the kept entries
//   through the single read port of the compact table, then the index read
//   one item at a time: item.ready is low until a prepare or sample result is taken
// reset: registers to num_categories 1, plain weights, threshold 0; support 0
// stall: a finished result sits in the output register; the block takes the
//   next item meanwhile, and a second result waits in the engine until free

module discrete_inverse_cdf_sampler_core import dics_pkg::*; #(
    parameter int MAX_CATEGORIES = DEF_MAX_CATEGORIES,
    parameter int TOTAL_BITS     = DEF_TOTAL_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    dics_item_if.sink       item,
    dics_result_if.source   result,
    dics_cfg_if.sink        cfg
);

    // configuration registers
    logic [NC_W-1:0]  nc_reg;
    logic             cum_reg;
    logic [THR_W-1:0] thr_reg;
    cfg_t             cfg_word;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg  <= NC_W'(1);
            cum_reg <= 1'b0;
            thr_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_NUM_CATEGORIES:     nc_reg  <= cfg.data[NC_W-1:0];
                REG_WEIGHTS_CUMULATIVE: cum_reg <= cfg.data[0];
                REG_ZERO_THRESHOLD:     thr_reg <= cfg.data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_word.num_categories     = nc_reg;
    assign cfg_word.weights_cumulative = cum_reg;
    assign cfg_word.zero_threshold     = thr_reg;

    // engine hookup: items go straight in when the sequencer is idle
    req_t req;
    res_t eng_res;
    logic eng_idle, eng_done, eng_take, start;

    assign req.command     = item.command;
    assign req.entry_index = item.entry_index;
    assign req.weight      = item.weight;
    assign req.draw        = item.draw;
    assign item.ready      = eng_idle;
    assign start           = item.valid && eng_idle;

    dics_engine #(
        .MAX_CATEGORIES (MAX_CATEGORIES),
        .TOTAL_BITS     (TOTAL_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .cfg   (cfg_word),
        .idle  (eng_idle),
        .done  (eng_done),
        .take  (eng_take),
        .res   (eng_res)
    );

    // output register: frees the engine as soon as a result is parked
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    assign eng_take = eng_done && (!out_valid_reg || result.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (eng_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = eng_res;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    // result transaction payload
    assign result.valid         = out_valid_reg;
    assign result.category      = out_res_reg.category;
    assign result.nonzero_count = out_res_reg.nonzero_count;
    assign result.is_report     = out_res_reg.is_report;
    assign result.no_support    = out_res_reg.no_support;

endmodule
